@@ design/fpws_pkg.sv @@
// ----------------------------------------------------------------------------
// File page write splitter package
// Shared widths, codes, the extent entry type and the sequencer states.
// ----------------------------------------------------------------------------
package fpws_pkg;

   localparam int FILE_COUNT     = 16;
   localparam int FILE_ID_WIDTH  = $clog2(FILE_COUNT);
   localparam int MAX_REQUEST    = 1024;
   localparam int MAX_RESULTS    = 33;
   localparam int COUNT_WIDTH    = $clog2(MAX_RESULTS);

   localparam int KIND_WIDTH     = 2;
   localparam int FIELD_WIDTH    = 16;
   localparam int LEN_WIDTH      = 11;
   localparam int ADDR_WIDTH     = 25;
   localparam int STATUS_WIDTH   = 2;
   localparam int SHIFT_WIDTH    = 4;

   localparam int REQ_TDATA_WIDTH = 80;
   localparam int RSP_TDATA_WIDTH = 40;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [KIND_WIDTH-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_READ  = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BEYOND   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ZERO_LEN = 2'd2;

   localparam logic CSR_INDEX_PAGE_SHIFT = 1'b0;

   localparam logic [SHIFT_WIDTH-1:0] PAGE_SHIFT_RESET = 4'd5;
   localparam logic [SHIFT_WIDTH-1:0] PAGE_SHIFT_MIN   = 4'd3;
   localparam logic [SHIFT_WIDTH-1:0] PAGE_SHIFT_MAX   = 4'd8;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] start_page;
      logic [FIELD_WIDTH-1:0] page_offset;
      logic [FIELD_WIDTH-1:0] file_size;
   } extent_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SPLIT
   } state_type;

endpackage

@@ design/fpws_extent_table.sv @@
// ----------------------------------------------------------------------------
// File extent table
// One entry per file, written by load items and read at one index; all
// entries are cleared by reset.
// ----------------------------------------------------------------------------
module fpws_extent_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [fpws_pkg::FILE_ID_WIDTH-1:0]  wr_index,
   input  fpws_pkg::extent_type                wr_entry,
   input  logic [fpws_pkg::FILE_ID_WIDTH-1:0]  rd_index,
   output fpws_pkg::extent_type                rd_entry
);
   import fpws_pkg::*;

   extent_type table_ff [FILE_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FILE_COUNT; i++) begin
            table_ff[i] <= '0;
         end
      end else if (wr_en) begin
         table_ff[wr_index] <= wr_entry;
      end
   end

   assign rd_entry = table_ff[rd_index];

endmodule

@@ design/file_page_write_splitter_unit.sv @@
// ----------------------------------------------------------------------------
// File page write splitter
// Looks up a file extent, forms the absolute device address and cuts write
// requests into transfers that each stay within one device page.
// Sequence: a request is registered and judged in ST_EVAL; loads, reads and
// errors give their single result from there, and writes go on to ST_SPLIT,
// one page chunk per cycle while the output is not stalled (at most 33
// chunks). A new request is taken only in ST_IDLE, after the last result.
// Reset: synchronous; clears the extent table and sets page_shift to 5.
// ----------------------------------------------------------------------------
module file_page_write_splitter_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // file_id[3:0], start_page[19:4], page_offset[35:20], file_size[51:36],
   // file_position[67:52], byte_count[78:68], zero pad[79]
   input  logic [fpws_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // kind[1:0]
   input  logic [fpws_pkg::KIND_WIDTH-1:0]       req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // address[24:0], chunk_length[35:25], zero pad[39:36]
   output logic [fpws_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   // status[1:0]
   output logic [fpws_pkg::STATUS_WIDTH-1:0]     rsp_tuser,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fpws_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [fpws_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [fpws_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import fpws_pkg::*;

   state_type                 state_ff, state_in;
   logic [SHIFT_WIDTH-1:0]    page_shift_ff;

   logic [KIND_WIDTH-1:0]     kind_ff;
   logic [FILE_ID_WIDTH-1:0]  fid_ff;
   extent_type                load_ff;
   logic [FIELD_WIDTH-1:0]    pos_ff;
   logic [LEN_WIDTH-1:0]      cnt_ff;

   logic [ADDR_WIDTH-1:0]     next_address_ff, next_address_in;
   logic [LEN_WIDTH-1:0]      bytes_left_ff, bytes_left_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;

   logic                      rsp_valid_ff;
   logic [ADDR_WIDTH-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [LEN_WIDTH-1:0]      rsp_len_ff, rsp_len_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [STATUS_WIDTH-1:0]   rsp_status_ff, rsp_status_in;
   logic                      emit;

   logic                      tbl_wr_en;
   extent_type                entry;

   logic [SHIFT_WIDTH-1:0]    shift;
   logic [8:0]                page_size;
   logic [7:0]                page_mask;
   logic [LEN_WIDTH-1:0]      room;
   logic [LEN_WIDTH-1:0]      chunk;
   logic [LEN_WIDTH-1:0]      remain;
   logic [ADDR_WIDTH-1:0]     base_address;
   logic                      too_long;
   logic                      req_accept;
   logic                      out_free;
   logic                      csr_write;

   fpws_extent_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_index (fid_ff),
      .wr_entry (load_ff),
      .rd_index (fid_ff),
      .rd_entry (entry)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_INDEX_PAGE_SHIFT) ?
                       CSR_DATA_WIDTH'(page_shift_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= PAGE_SHIFT_RESET;
      end else if (csr_write && csr_paddr[2] == CSR_INDEX_PAGE_SHIFT) begin
         page_shift_ff <= csr_pwdata[SHIFT_WIDTH-1:0];
      end
   end

   always_comb begin
      if (page_shift_ff < PAGE_SHIFT_MIN) begin
         shift = PAGE_SHIFT_MIN;
      end else if (page_shift_ff > PAGE_SHIFT_MAX) begin
         shift = PAGE_SHIFT_MAX;
      end else begin
         shift = page_shift_ff;
      end
   end

   assign page_size = 9'd1 << shift;
   assign page_mask = 8'(page_size - 9'd1);
   assign room      = LEN_WIDTH'(page_size) -
                      LEN_WIDTH'(next_address_ff[7:0] & page_mask);
   assign chunk     = (bytes_left_ff < room) ? bytes_left_ff : room;
   assign remain    = bytes_left_ff - chunk;

   assign base_address = (ADDR_WIDTH'(entry.start_page) << shift) +
                         ADDR_WIDTH'(entry.page_offset) + ADDR_WIDTH'(pos_ff);
   assign too_long = (cnt_ff > LEN_WIDTH'(MAX_REQUEST)) ||
                     ((17'(pos_ff) + 17'(cnt_ff)) > 17'(entry.file_size));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff             <= req_tuser;
         fid_ff              <= req_tdata[3:0];
         load_ff.start_page  <= req_tdata[19:4];
         load_ff.page_offset <= req_tdata[35:20];
         load_ff.file_size   <= req_tdata[51:36];
         pos_ff              <= req_tdata[67:52];
         cnt_ff              <= req_tdata[78:68];
      end
   end

   always_comb begin
      state_in        = state_ff;
      next_address_in = next_address_ff;
      bytes_left_in   = bytes_left_ff;
      count_in        = count_ff;
      tbl_wr_en       = 1'b0;
      emit            = 1'b0;
      rsp_addr_in     = '0;
      rsp_len_in      = '0;
      rsp_last_in     = 1'b1;
      rsp_status_in   = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_tuser inside {KIND_LOAD, KIND_WRITE, KIND_READ}) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (kind_ff == KIND_LOAD) begin
                  tbl_wr_en = 1'b1;
                  emit      = 1'b1;
               end else if (cnt_ff == '0) begin
                  emit          = 1'b1;
                  rsp_status_in = STATUS_ZERO_LEN;
               end else if (too_long) begin
                  emit          = 1'b1;
                  rsp_status_in = STATUS_BEYOND;
               end else if (kind_ff == KIND_READ) begin
                  emit        = 1'b1;
                  rsp_addr_in = base_address;
                  rsp_len_in  = cnt_ff;
               end else begin
                  next_address_in = base_address;
                  bytes_left_in   = cnt_ff;
                  count_in        = '0;
                  state_in        = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_addr_in     = next_address_ff;
               rsp_len_in      = chunk;
               rsp_last_in     = (remain == '0) ||
                                 (count_ff == COUNT_WIDTH'(MAX_RESULTS - 1));
               next_address_in = next_address_ff + ADDR_WIDTH'(chunk);
               bytes_left_in   = remain;
               count_in        = count_ff + 1'b1;
               if (rsp_last_in) begin
                  bytes_left_in = '0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         next_address_ff <= '0;
         bytes_left_ff   <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         next_address_ff <= next_address_in;
         bytes_left_ff   <= bytes_left_in;
         count_ff        <= count_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_len_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
